[design/gcs_pkg.sv]
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types and character codes for the comment stripper.
// ----------------------------------------------------------------------------
package gcs_pkg;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNl     = 8'h0A;

  localparam int unsigned OfifoDepth = 4;

  typedef enum logic [8:0] {
    ModeNormal = 9'b000000001,
    ModeSlash  = 9'b000000010,
    ModeLine   = 9'b000000100,
    ModeBlock  = 9'b000001000,
    ModeBstar  = 9'b000010000,
    ModeStr    = 9'b000100000,
    ModeStrEsc = 9'b001000000,
    ModeChr    = 9'b010000000,
    ModeChrEsc = 9'b100000000
  } gcs_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       run_last;
    logic       stream_end;
  } gcs_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    gcs_res_t   r0;
    gcs_res_t   r1;
  } gcs_push_t;

  function automatic gcs_mode_e open_mode(logic [7:0] b);
    gcs_mode_e m;
    m = ModeNormal;
    if (b == ChDquote) begin
      m = ModeStr;
    end else if (b == ChSquote) begin
      m = ModeChr;
    end
    return m;
  endfunction

endpackage

[design/gcs_scan.sv]
// ----------------------------------------------------------------------------
// gcs_scan
// Scan mode register and per-byte decode into zero, one or two results.
// ----------------------------------------------------------------------------
module gcs_scan import gcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output gcs_push_t  push_o
);

  gcs_mode_e  mode_q, mode_d;
  logic [1:0] cnt;
  logic [7:0] b0, b1;
  logic       has0;

  always_comb begin
    mode_d = mode_q;
    cnt    = 2'd0;
    b0     = '0;
    b1     = '0;
    has0   = 1'b1;
    unique case (mode_q)
      ModeSlash: begin
        if (byte_i == ChSlash) begin
          mode_d = ModeLine;
        end else if (byte_i == ChStar) begin
          mode_d = ModeBlock;
        end else begin
          cnt    = 2'd2;
          b0     = ChSlash;
          b1     = byte_i;
          mode_d = open_mode(byte_i);
        end
      end
      ModeLine: begin
        if (byte_i == ChNl) begin
          cnt    = 2'd1;
          b0     = byte_i;
          mode_d = ModeNormal;
        end
      end
      ModeBlock, ModeBstar: begin
        if (mode_q == ModeBstar && byte_i == ChSlash) begin
          mode_d = ModeNormal;
        end else if (byte_i == ChStar) begin
          mode_d = ModeBstar;
        end else begin
          mode_d = ModeBlock;
        end
      end
      ModeStr, ModeChr: begin
        cnt = 2'd1;
        b0  = byte_i;
        if (byte_i == ChBslash && !last_i) begin
          mode_d = (mode_q == ModeStr) ? ModeStrEsc : ModeChrEsc;
        end else if (byte_i == ((mode_q == ModeStr) ? ChDquote : ChSquote)) begin
          mode_d = ModeNormal;
        end
      end
      ModeStrEsc: begin
        cnt    = 2'd1;
        b0     = byte_i;
        mode_d = ModeStr;
      end
      ModeChrEsc: begin
        cnt    = 2'd1;
        b0     = byte_i;
        mode_d = ModeChr;
      end
      default: begin
        if (byte_i == ChSlash) begin
          mode_d = ModeSlash;
        end else begin
          cnt    = 2'd1;
          b0     = byte_i;
          mode_d = open_mode(byte_i);
        end
      end
    endcase

    // flush a held slash, or emit the empty end marker
    if (last_i) begin
      if (mode_d == ModeSlash) begin
        cnt = 2'd1;
        b0  = ChSlash;
      end else if (cnt == 2'd0) begin
        cnt  = 2'd1;
        b0   = '0;
        has0 = 1'b0;
      end
      mode_d = ModeNormal;
    end
  end

  always_comb begin
    push_o.cnt           = step_i ? cnt : 2'd0;
    push_o.r0.data       = b0;
    push_o.r0.has_byte   = has0;
    push_o.r0.run_last   = (cnt == 2'd1);
    push_o.r0.stream_end = last_i;
    push_o.r1.data       = b1;
    push_o.r1.has_byte   = 1'b1;
    push_o.r1.run_last   = 1'b1;
    push_o.r1.stream_end = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
    end else if (step_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

[design/gcs_ofifo.sv]
// ----------------------------------------------------------------------------
// gcs_ofifo
// Result queue: takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module gcs_ofifo import gcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gcs_push_t push_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output gcs_res_t  res_o
);

  localparam int unsigned PtrW = $clog2(OfifoDepth);
  localparam int unsigned CntW = $clog2(OfifoDepth + 1);

  gcs_res_t        mem_q [OfifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(OfifoDepth - 2));
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + CntW'(push_i.cnt) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[design/glsl_comment_stripper.sv]
// ----------------------------------------------------------------------------
// glsl_comment_stripper
// Streaming remover of line and block comments, string and literal aware.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata           | tuser                     | tlast
//  s_axis   | in  | [7:0] in_byte   | -                         | in_last
//  m_axis   | out | [7:0] out_byte  | [0] has_byte [1] stream_end | run_last
//
//  One byte per cycle enters while the result queue has room; it is held
//  in the input register, decoded there, and its results are written to the result queue.
//  A byte yields up to two results, which a four-entry result queue drains
//  one per cycle while m_axis is ready; input stalls only while that queue
//  has fewer than two free entries. Reset returns the scan mode to normal
//  text and empties both the input register and the queue.
// ----------------------------------------------------------------------------
module glsl_comment_stripper import gcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [0] has_byte, [1] stream_end
  output logic       m_axis_tlast_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       room;
  logic       step;
  logic       in_xfer;
  gcs_push_t  push;
  gcs_res_t   res;

  assign step            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  gcs_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  gcs_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  assign m_axis_tdata_o = res.data;
  assign m_axis_tuser_o = {res.stream_end, res.has_byte};
  assign m_axis_tlast_o = res.run_last;

endmodule

[design/gcs_checker.sv]
// ----------------------------------------------------------------------------
// gcs_checker
// Port-level checks for the comment stripper, bound to the top level.
// ----------------------------------------------------------------------------
module gcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [1:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled output transfer changed");

  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      m_axis_tlast_o && m_axis_tuser_o[1] && m_axis_tdata_o == 8'h00)
    else $error("malformed end marker");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o && s_axis_tready_o)
    else $error("not empty after reset");

endmodule

bind glsl_comment_stripper gcs_checker u_gcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
